@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ src/rdrs_pkg.sv @@
// Types and constants of the receive descriptor ring segmenter.
`default_nettype none
package rdrs_pkg;

  localparam int MAX_SEGS = 8;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW = 1;

  localparam logic CMD_WRITE   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_ZERO     = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_TOO_LONG = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_RELEASE,
    OP_WRITE,
    OP_REJECT
  } op_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SEG
  } back_state_t;

  typedef struct packed {
    logic        cmd;
    logic [11:0] pkt_len;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  desc_index;
    logic [8:0]  seg_len;
    logic        eop;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_kind_t    kind;
    status_t     status;
    logic [11:0] pkt_len;
  } cmd_entry_t;

  typedef struct packed {
    logic       valid;
    cmd_entry_t entry;
  } cmdq_head_t;

endpackage
`default_nettype wire

@@ src/rx_descriptor_ring_segmenter.sv @@
// Top level of the receive descriptor ring segmenter.
`default_nettype none
`include "assert_macros.svh"
// A write command (cmd 0) splits pkt_len into segments of at most SEGMENT_BYTES,
// stores each in the descriptor ring at the tail and returns one result beat per
// segment; a release command (cmd 1) frees the head slot and returns its length
// and end-of-packet mark. Refused writes, a full ring and an empty ring each end
// the command with one error beat carrying last. The front end classifies a
// command in the cycle it is taken and queues it (two entries); the back end
// dispatches a write and then stores its segments one at a time (up to eight
// segments), since the descriptor memory has a single write port; a release of a
// live slot passes through the registered memory read before its beat. Ring
// slots hold no reset value and need no clearing after reset. device_enable is
// to be written on the cfg channel only while idle; the block does not enforce it.
module rx_descriptor_ring_segmenter #(
  parameter int RING_ENTRIES     = 64,
  parameter int SEGMENT_BYTES    = 256,
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire rdrs_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output rdrs_pkg::out_item_t      out_data
);

  logic                 q_full, q_push, q_pop;
  rdrs_pkg::cmd_entry_t q_entry;
  rdrs_pkg::cmdq_head_t q_head;
  logic                 ok_beat, err_beat, err_shape;

  rdrs_front #(
    .SEGMENT_BYTES   (SEGMENT_BYTES),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  rdrs_cmd_fifo u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_entry(q_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  rdrs_back #(
    .RING_ENTRIES (RING_ENTRIES),
    .SEGMENT_BYTES(SEGMENT_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // a release beat always carries last, whatever its stored eop
  assign ok_beat   = out_valid && out_data.status == rdrs_pkg::ST_OK;
  assign err_beat  = out_valid && out_data.status != rdrs_pkg::ST_OK;
  assign err_shape = out_data.last && !out_data.eop && out_data.seg_len == 9'd0;

  `ASSERT_IMPLIES(a_ok_eop_is_last, clk, rst_n, ok_beat && out_data.eop, out_data.last)
  `ASSERT_IMPLIES(a_err_beat_shape, clk, rst_n, err_beat, err_shape)
  `ASSERT_IMPLIES(a_no_push_when_full, clk, rst_n, q_full, !q_push)
  `ASSERT_IMPLIES(a_pop_needs_entry, clk, rst_n, q_pop, q_head.valid)

endmodule
`default_nettype wire

@@ src/rdrs_front.sv @@
// Front end: device enable register and command classification.
`default_nettype none
module rdrs_front #(
  parameter int SEGMENT_BYTES    = 256,
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rdrs_pkg::in_item_t in_data,
  input  wire logic               q_full,
  output logic                    q_push,
  output rdrs_pkg::cmd_entry_t    q_entry
);

  localparam logic [17:0] MAX_LEN = 18'(MAX_PACKET_BYTES);
  localparam logic [17:0] SEG_CAP = 18'(rdrs_pkg::MAX_SEGS * SEGMENT_BYTES);

  logic        device_enable_r;
  logic [17:0] len_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_enable_r <= 1'b0;
    end else if (cfg_valid) begin
      device_enable_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign q_push    = in_valid && !q_full;
  assign len_w     = {6'b0, in_data.pkt_len};

  always_comb begin
    q_entry.pkt_len = in_data.pkt_len;
    q_entry.kind    = rdrs_pkg::OP_REJECT;
    q_entry.status  = rdrs_pkg::ST_OK;
    if (in_data.cmd == rdrs_pkg::CMD_RELEASE) begin
      q_entry.kind = rdrs_pkg::OP_RELEASE;
    end else if (!device_enable_r) begin
      q_entry.status = rdrs_pkg::ST_DISABLED;
    end else if (in_data.pkt_len == '0) begin
      q_entry.status = rdrs_pkg::ST_ZERO;
    end else if (len_w > MAX_LEN || len_w > SEG_CAP) begin
      // more than eight segments is refused like an oversize packet
      q_entry.status = rdrs_pkg::ST_TOO_LONG;
    end else begin
      q_entry.kind = rdrs_pkg::OP_WRITE;
    end
  end

endmodule
`default_nettype wire

@@ src/rdrs_cmd_fifo.sv @@
// Two-entry command queue between front and back end.
`default_nettype none
module rdrs_cmd_fifo (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire rdrs_pkg::cmd_entry_t push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output rdrs_pkg::cmdq_head_t      head
);

  localparam int CW = rdrs_pkg::CMDQ_AW + 1;

  rdrs_pkg::cmd_entry_t            slots_r [rdrs_pkg::CMDQ_DEPTH];
  logic [rdrs_pkg::CMDQ_AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]                   count_r, count_nxt;
  logic                            do_pop;

  assign full       = count_r == CW'(rdrs_pkg::CMDQ_DEPTH);
  assign head.valid = count_r != '0;
  assign head.entry = slots_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

@@ src/rdrs_back.sv @@
// Back end: ring pointers, descriptor memory, segment sequencer, result register.
`default_nettype none
module rdrs_back #(
  parameter int RING_ENTRIES  = 64,
  parameter int SEGMENT_BYTES = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire rdrs_pkg::cmdq_head_t q_head,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output rdrs_pkg::out_item_t       out_data
);

  localparam int IDX_W = $clog2(RING_ENTRIES);

  rdrs_pkg::back_state_t state_r, state_nxt;
  rdrs_pkg::out_item_t   out_r, out_nxt;
  logic                  out_valid_r;

  logic [IDX_W-1:0]  head_r, tail_r, tail_next, head_next;
  logic [IDX_W+5:0]  head_wide, tail_wide;
  logic [5:0]        head6, tail6;
  logic [11:0]       rem_r, seg_w;
  logic              rem_big, ring_full, ring_empty, can_load;
  logic              load, mem_we, mem_re, head_inc, tail_inc;
  logic [9:0]        mem [RING_ENTRIES];
  logic [9:0]        rd_r;

  assign tail_next  = (tail_r == IDX_W'(RING_ENTRIES - 1)) ? '0 : tail_r + 1'b1;
  assign head_next  = (head_r == IDX_W'(RING_ENTRIES - 1)) ? '0 : head_r + 1'b1;
  assign ring_full  = tail_next == head_r;
  assign ring_empty = head_r == tail_r;
  assign head_wide  = {6'b0, head_r};
  assign tail_wide  = {6'b0, tail_r};
  assign head6      = head_wide[5:0];
  assign tail6      = tail_wide[5:0];
  assign can_load   = !out_valid_r || out_ready;

  // rem_big: more than one segment's worth remains, so this segment is not the last
  assign rem_big = {6'b0, rem_r} > 18'(SEGMENT_BYTES);
  assign seg_w   = rem_big ? 12'(SEGMENT_BYTES) : rem_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rdrs_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          if (q_head.entry.kind == rdrs_pkg::OP_WRITE) begin
            state_nxt = rdrs_pkg::BK_SEG;
          end else if (q_head.entry.kind == rdrs_pkg::OP_RELEASE && !ring_empty) begin
            state_nxt = rdrs_pkg::BK_READ;
          end
        end
      end
      rdrs_pkg::BK_READ: begin
        if (can_load) begin
          state_nxt = rdrs_pkg::BK_IDLE;
        end
      end
      rdrs_pkg::BK_SEG: begin
        if (can_load && (ring_full || !rem_big)) begin
          state_nxt = rdrs_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rdrs_pkg::BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    load     = 1'b0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    head_inc = 1'b0;
    tail_inc = 1'b0;
    out_nxt  = out_r;
    case (state_r)
      rdrs_pkg::BK_IDLE: begin
        if (q_head.valid) begin
          case (q_head.entry.kind)
            rdrs_pkg::OP_WRITE: begin
              q_pop = 1'b1;
            end
            rdrs_pkg::OP_RELEASE: begin
              if (!ring_empty) begin
                q_pop  = 1'b1;
                mem_re = 1'b1;
              end else if (can_load) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                out_nxt = '{rdrs_pkg::ST_EMPTY, head6, 9'd0, 1'b0, 1'b1};
              end
            end
            rdrs_pkg::OP_REJECT: begin
              if (can_load) begin
                q_pop   = 1'b1;
                load    = 1'b1;
                out_nxt = '{q_head.entry.status, tail6, 9'd0, 1'b0, 1'b1};
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      rdrs_pkg::BK_READ: begin
        if (can_load) begin
          load     = 1'b1;
          head_inc = 1'b1;
          out_nxt  = '{rdrs_pkg::ST_OK, head6, rd_r[8:0], rd_r[9], 1'b1};
        end
      end
      rdrs_pkg::BK_SEG: begin
        if (can_load) begin
          load = 1'b1;
          if (ring_full) begin
            out_nxt = '{rdrs_pkg::ST_FULL, tail6, 9'd0, 1'b0, 1'b1};
          end else begin
            mem_we   = 1'b1;
            tail_inc = 1'b1;
            out_nxt  = '{rdrs_pkg::ST_OK, tail6, seg_w[8:0], !rem_big, !rem_big};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rdrs_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (head_inc) begin
        head_r <= head_next;
      end
      if (tail_inc) begin
        tail_r <= tail_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
    if (q_pop && q_head.entry.kind == rdrs_pkg::OP_WRITE) begin
      rem_r <= q_head.entry.pkt_len;
    end else if (tail_inc) begin
      rem_r <= rem_r - seg_w;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[tail_r] <= {!rem_big, seg_w[8:0]};
    end
    if (mem_re) begin
      rd_r <= mem[head_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

@@ tb/ring_beat_checker.sv @@
// Checker for the descriptor ring: predicts result beats from accepted commands and compares.
`timescale 1ns / 100ps
module ring_beat_checker #(
  parameter int RING_ENTRIES     = 64,
  parameter int SEGMENT_BYTES    = 256,
  parameter int MAX_PACKET_BYTES = 2048,
  parameter int MAX_PRINTS       = 40
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  rdrs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  rdrs_pkg::out_item_t out_data,
  output int                  mismatches,
  output int                  outstanding,
  output int                  beats_checked,
  output int                  full_events,
  output int                  empty_events
);

  rdrs_pkg::out_item_t expected_beats[$];
  rdrs_pkg::out_item_t want;
  logic                enable_m;
  int                  ring_head_m;
  int                  ring_tail_m;
  logic [8:0]          slot_len_m [RING_ENTRIES];
  logic                slot_eop_m [RING_ENTRIES];

  initial begin
    mismatches    = 0;
    outstanding   = 0;
    beats_checked = 0;
    full_events   = 0;
    empty_events  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("%0t ns mismatch: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic push_beat(input rdrs_pkg::status_t st, input int idx, input int len,
                           input logic eop, input logic last);
    rdrs_pkg::out_item_t b;
    b.status     = st;
    b.desc_index = 6'(idx);
    b.seg_len    = 9'(len);
    b.eop        = eop;
    b.last       = last;
    expected_beats.push_back(b);
  endtask

  task automatic predict_ring_beats(input rdrs_pkg::in_item_t item);
    int   len;
    int   nseg;
    int   remaining;
    int   seg;
    int   i;
    logic seg_eop;
    bit   halted;
    len = int'(item.pkt_len);
    if (item.cmd == rdrs_pkg::CMD_RELEASE) begin
      if (ring_head_m == ring_tail_m) begin
        push_beat(rdrs_pkg::ST_EMPTY, ring_head_m, 0, 1'b0, 1'b1);
        empty_events++;
      end else begin
        push_beat(rdrs_pkg::ST_OK, ring_head_m, int'(slot_len_m[ring_head_m]),
                  slot_eop_m[ring_head_m], 1'b1);
        ring_head_m = (ring_head_m + 1) % RING_ENTRIES;
      end
    end else if (!enable_m) begin
      push_beat(rdrs_pkg::ST_DISABLED, ring_tail_m, 0, 1'b0, 1'b1);
    end else if (len == 0) begin
      push_beat(rdrs_pkg::ST_ZERO, ring_tail_m, 0, 1'b0, 1'b1);
    end else begin
      nseg = (len + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
      if (len > MAX_PACKET_BYTES || nseg > rdrs_pkg::MAX_SEGS) begin
        push_beat(rdrs_pkg::ST_TOO_LONG, ring_tail_m, 0, 1'b0, 1'b1);
      end else begin
        remaining = len;
        halted    = 1'b0;
        for (i = 0; i < nseg && !halted; i++) begin
          // one slot stays free, so tail+1 == head means full
          if ((ring_tail_m + 1) % RING_ENTRIES == ring_head_m) begin
            push_beat(rdrs_pkg::ST_FULL, ring_tail_m, 0, 1'b0, 1'b1);
            full_events++;
            halted = 1'b1;
          end else begin
            seg     = (remaining > SEGMENT_BYTES) ? SEGMENT_BYTES : remaining;
            seg_eop = (remaining <= SEGMENT_BYTES);
            slot_len_m[ring_tail_m] = 9'(seg);
            slot_eop_m[ring_tail_m] = seg_eop;
            push_beat(rdrs_pkg::ST_OK, ring_tail_m, seg, seg_eop, seg_eop);
            ring_tail_m = (ring_tail_m + 1) % RING_ENTRIES;
            remaining   = remaining - seg;
          end
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      enable_m    = 1'b0;
      ring_head_m = 0;
      ring_tail_m = 0;
      expected_beats.delete();
    end else begin
      if (in_valid && in_ready) begin
        predict_ring_beats(in_data);
      end
      if (cfg_valid && cfg_ready) begin
        enable_m = cfg_data;
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected result beat %p", out_data));
        end else begin
          want = expected_beats.pop_front();
          if (out_data.status !== want.status) begin
            report_mismatch($sformatf("beat %0d status got %0d exp %0d",
                                      beats_checked, out_data.status, want.status));
          end
          if (out_data.desc_index !== want.desc_index) begin
            report_mismatch($sformatf("beat %0d desc_index got %0d exp %0d",
                                      beats_checked, out_data.desc_index,
                                      want.desc_index));
          end
          if (out_data.seg_len !== want.seg_len) begin
            report_mismatch($sformatf("beat %0d seg_len got %0d exp %0d",
                                      beats_checked, out_data.seg_len, want.seg_len));
          end
          if (out_data.eop !== want.eop) begin
            report_mismatch($sformatf("beat %0d eop got %0b exp %0b",
                                      beats_checked, out_data.eop, want.eop));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("beat %0d last got %0b exp %0b",
                                      beats_checked, out_data.last, want.last));
          end
        end
        beats_checked++;
      end
    end
    outstanding = expected_beats.size();
  end

endmodule

@@ tb/rx_descriptor_ring_segmenter_tb.sv @@
// Top of the descriptor ring testbench: clock, reset, command and config stimulus, verdict.
`timescale 1ns / 100ps
module rx_descriptor_ring_segmenter_tb;

  localparam int RING_ENTRIES     = 64;
  localparam int SEGMENT_BYTES    = 256;
  localparam int MAX_PACKET_BYTES = 2048;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int SETTLE_CYCLES    = 16;

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  logic                cfg_data;
  logic                in_valid;
  logic                in_ready;
  rdrs_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  rdrs_pkg::out_item_t out_data;

  int mismatches;
  int outstanding;
  int beats_checked;
  int full_events;
  int empty_events;
  int cmds_sent   = 0;
  int cycle_count = 0;
  bit no_idle     = 1'b0;

  rx_descriptor_ring_segmenter #(
    .RING_ENTRIES    (RING_ENTRIES),
    .SEGMENT_BYTES   (SEGMENT_BYTES),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  ring_beat_checker #(
    .RING_ENTRIES    (RING_ENTRIES),
    .SEGMENT_BYTES   (SEGMENT_BYTES),
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .beats_checked(beats_checked),
    .full_events  (full_events),
    .empty_events (empty_events)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               outstanding);
      $display("tb: failure");
      $finish;
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 29);
  end

  task automatic send_beat(input logic cmd, input int len);
    @(negedge clk);
    // each cycle idles with the same odds before the beat goes out
    if (!no_idle) begin
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_data.cmd     <= cmd;
    in_data.pkt_len <= 12'(len);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cmds_sent++;
  endtask

  // drop valid and wait until every predicted beat has come back
  task automatic drain_ring;
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    drain_ring();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count, input bit quiet_stretch);
    int   n;
    int   write_pct;
    int   r;
    int   len;
    logic cmd;
    write_pct = 50;
    for (n = 0; n < count; n++) begin
      // shift the write/release mix so the ring swings between full and empty
      if (n % 20 == 0) begin
        case ($urandom_range(4))
          0:       write_pct = 90;
          1:       write_pct = 70;
          2:       write_pct = 50;
          3:       write_pct = 30;
          default: write_pct = 15;
        endcase
      end
      no_idle = quiet_stretch && (n < 70);
      cmd = rdrs_pkg::CMD_RELEASE;
      len = $urandom_range(4095);
      if ($urandom_range(99) < write_pct) begin
        cmd = rdrs_pkg::CMD_WRITE;
        r   = $urandom_range(99);
        if (r < 55) begin
          len = $urandom_range(512, 1);
        end else if (r < 80) begin
          len = $urandom_range(MAX_PACKET_BYTES, 1);
        end else if (r < 90) begin
          len = $urandom_range(8, 1) * SEGMENT_BYTES - $urandom_range(1);
        end else if (r < 95) begin
          len = 0;
        end else begin
          len = $urandom_range(4095, MAX_PACKET_BYTES + 1);
        end
      end
      send_beat(cmd, len);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int i;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_ready = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // device comes up disabled
    send_beat(rdrs_pkg::CMD_RELEASE, 0);
    send_beat(rdrs_pkg::CMD_WRITE, 100);
    send_beat(rdrs_pkg::CMD_WRITE, 0);
    write_enable(1'b1);
    send_beat(rdrs_pkg::CMD_WRITE, 0);
    send_beat(rdrs_pkg::CMD_WRITE, MAX_PACKET_BYTES + 1);
    send_beat(rdrs_pkg::CMD_WRITE, 4095);
    send_beat(rdrs_pkg::CMD_WRITE, MAX_PACKET_BYTES);
    send_beat(rdrs_pkg::CMD_WRITE, 1);
    send_beat(rdrs_pkg::CMD_WRITE, SEGMENT_BYTES);
    send_beat(rdrs_pkg::CMD_WRITE, SEGMENT_BYTES + 1);
    for (i = 0; i < 4; i++) send_beat(rdrs_pkg::CMD_RELEASE, 4095);
    send_beat(rdrs_pkg::CMD_WRITE, 512);
    // fill the ring until a packet is cut short, then hit it while full
    for (i = 0; i < 7; i++) send_beat(rdrs_pkg::CMD_WRITE, MAX_PACKET_BYTES);
    send_beat(rdrs_pkg::CMD_WRITE, 1);
    write_enable(1'b0);
    send_beat(rdrs_pkg::CMD_RELEASE, 2730);
    send_beat(rdrs_pkg::CMD_WRITE, 300);

    write_enable(1'b1);
    run_random_phase(130, 1'b0);
    write_enable(1'b0);
    run_random_phase(25, 1'b0);
    write_enable(1'b1);
    run_random_phase(130, 1'b1);

    drain_ring();
    $display("summary: %0d commands sent, %0d result beats checked", cmds_sent,
             beats_checked);
    $display("summary: ring ran full %0d times, release on empty ring %0d times",
             full_events, empty_events);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
